// ===== sv/bcm_pkg.sv =====
// Shared widths, codes and types of the MRU block cache.
package bcm_pkg;

  localparam int ENTRIES_DEF         = 64;
  localparam int BLOCK_WORDS_DEF     = 32;
  localparam int DISKS_DEF           = 16;
  localparam int BLOCKS_PER_DISK_DEF = 256;
  localparam int MIN_IN_USE          = 2;
  localparam int RESET_IN_USE        = 64;

  localparam int DISK_W  = 4;
  localparam int BLOCK_W = 8;
  localparam int WORD_W  = 64;
  localparam int CNT_W   = 32;
  localparam int USE_W   = 7;
  localparam int CFG_W   = 7;
  localparam int CFG_A_W = 1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_OFF  = 2'd3;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [CFG_A_W-1:0] REG_CACHE_ON = 1'd0;
  localparam logic [CFG_A_W-1:0] REG_IN_USE   = 1'd1;

  typedef struct packed {
    logic               vld;
    logic [DISK_W-1:0]  disk;
    logic [BLOCK_W-1:0] blk;
    logic [CNT_W-1:0]   stamp;
  } tag_ent_t;

endpackage

// ===== sv/bcm_ram.sv =====
// Simple dual-port RAM with one write port and a registered read port.
module bcm_ram #(
  parameter int W = 8,
  parameter int D = 2,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/block_cache_mru_replace_core.sv =====
// Fully associative disk-block cache with most-recently-used replacement.
// Input channel (in_*): one beat is a lookup (opcode 0) or one payload word of an insert
// (opcode 1); insert words are staged until the beat with in_word_last set.
// Result channel (out_*): a lookup hit returns BLOCK_WORDS beats, the last one marked;
// every other finished request returns one beat with out_result_last set. Non-last
// insert words return nothing.
// Config port (cfg_*): index 0 enables the cache, index 1 sets the entries searched
// (values below 2 or above ENTRIES are dropped). Write only while the block is idle.
// Timing: one request at a time. A tag search reads the tag RAM once per entry in use.
// A lookup hit then streams each word via a block RAM read and the output register.
// An insert miss copies the staging RAM into the block RAM word by word (staging read,
// then block write); an insert hit compares words first and on a difference rescans
// the tags and rewrites every matching entry.
// Reset: the tag RAM is swept clear, one entry per cycle; in_ready stays low meanwhile.
// Config writes are taken throughout.
// Stall: a result waits in the output register; the engine holds until it is taken.
module block_cache_mru_replace_core #(
  parameter int ENTRIES         = bcm_pkg::ENTRIES_DEF,
  parameter int BLOCK_WORDS     = bcm_pkg::BLOCK_WORDS_DEF,
  parameter int DISKS           = bcm_pkg::DISKS_DEF,
  parameter int BLOCKS_PER_DISK = bcm_pkg::BLOCKS_PER_DISK_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_opcode,
  input  logic [bcm_pkg::DISK_W-1:0]   in_disk_id,
  input  logic [bcm_pkg::BLOCK_W-1:0]  in_block_id,
  input  logic [bcm_pkg::WORD_W-1:0]   in_data_word,
  input  logic                         in_word_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [bcm_pkg::WORD_W-1:0]   out_read_word,
  output logic                         out_result_last,
  output logic [bcm_pkg::CNT_W-1:0]    out_query_count,
  output logic [bcm_pkg::CNT_W-1:0]    out_hit_count,
  input  logic                         cfg_we,
  input  logic [bcm_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [bcm_pkg::CFG_W-1:0]    cfg_wdata
);
  import bcm_pkg::*;

  localparam int EW   = $clog2(ENTRIES);
  localparam int WW   = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam int SCW  = $clog2(BLOCK_WORDS + 1);
  localparam int BD   = ENTRIES * BLOCK_WORDS;
  localparam int BAW  = $clog2(BD);
  localparam int CMPW = (EW > USE_W) ? EW : USE_W;
  localparam int RST_USE = (RESET_IN_USE > ENTRIES) ? ENTRIES : RESET_IN_USE;
  localparam int TW   = $bits(tag_ent_t);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SCAN, S_SDRAIN, S_DECIDE, S_STRD, S_STOUT,
    S_CMPRD, S_CMPCHK, S_OVRRD, S_OVRCHK, S_CPRD, S_CPWR, S_EMIT
  } state_t;

  state_t state_r;

  logic             on_r;
  logic [USE_W-1:0] use_r;
  logic [CNT_W-1:0] queries_r, hits_r, ctr_r, best_r;
  logic             op_r;
  logic [DISK_W-1:0]  disk_r;
  logic [BLOCK_W-1:0] blk_r;
  logic [SCW-1:0]   stg_cnt_r, pcnt_r;
  logic [EW-1:0]    scan_i_r, ev_i_r, hit_idx_r, inv_idx_r, vic_idx_r, dst_r;
  logic             ev_vld_r, hit_r, inv_r, vic_r, ovr_r;
  logic [WW-1:0]    w_r;
  logic [1:0]       res_st_r;

  logic                out_valid_r, out_last_r;
  logic [1:0]          out_status_r;
  logic [WORD_W-1:0]   out_word_r;
  logic [CNT_W-1:0]    out_q_r, out_h_r;

  // memory ports
  logic          tag_we, tag_re;
  logic [EW-1:0] tag_waddr;
  tag_ent_t      tag_wdata, tag_rd;
  logic [TW-1:0] tag_rdata;
  logic          blk_we, blk_re;
  logic [BAW-1:0] blk_waddr, blk_raddr;
  logic [WORD_W-1:0] blk_rdata;
  logic          stg_we, stg_re;
  logic [WW-1:0] stg_waddr, stg_raddr;
  logic [WORD_W-1:0] stg_rdata, stg_word;

  logic in_acc, slot_free, out_load, scan_end, w_end, match, tag_bad;
  logic [SCW-1:0] stg_cnt_nxt;
  logic [USE_W-1:0] n_m1;

  assign tag_rd    = tag_ent_t'(tag_rdata);
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_load  = slot_free && ((state_r == S_STOUT) || (state_r == S_EMIT));
  assign n_m1      = use_r - USE_W'(1);
  assign scan_end  = (CMPW'(scan_i_r) == CMPW'(n_m1));
  assign w_end     = (w_r == WW'(BLOCK_WORDS - 1));
  assign match     = tag_rd.vld && (tag_rd.disk == disk_r) && (tag_rd.blk == blk_r);
  assign stg_word  = (SCW'(w_r) < pcnt_r) ? stg_rdata : '0;
  assign stg_cnt_nxt = (stg_cnt_r < SCW'(BLOCK_WORDS)) ? stg_cnt_r + SCW'(1) : stg_cnt_r;
  assign tag_bad   = (int'(in_disk_id) >= DISKS) || (int'(in_block_id) >= BLOCKS_PER_DISK);

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_word   = out_word_r;
  assign out_result_last = out_last_r;
  assign out_query_count = out_q_r;
  assign out_hit_count   = out_h_r;

  function automatic logic [BAW-1:0] baddr(input logic [EW-1:0] e, input logic [WW-1:0] w);
    baddr = BAW'(e) * BAW'(BLOCK_WORDS) + BAW'(w);
  endfunction

  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = scan_i_r;
    tag_wdata = '{vld: 1'b1, disk: disk_r, blk: blk_r, stamp: ctr_r};
    tag_re    = 1'b0;
    blk_we    = 1'b0;
    blk_waddr = baddr(dst_r, w_r);
    blk_re    = 1'b0;
    blk_raddr = baddr(hit_idx_r, w_r);
    stg_re    = 1'b0;
    stg_raddr = w_r;
    stg_we    = in_acc && (in_opcode == OP_INSERT) && (stg_cnt_r < SCW'(BLOCK_WORDS));
    stg_waddr = stg_cnt_r[WW-1:0];
    unique case (state_r)
      S_CLR: begin
        tag_we    = 1'b1;
        tag_wdata = '0;
      end
      S_SCAN, S_OVRRD: tag_re = 1'b1;
      S_DECIDE: begin
        if (op_r == OP_LOOKUP) begin
          tag_we    = hit_r;
          tag_waddr = hit_idx_r;
        end else begin
          tag_we    = hit_r || inv_r || vic_r;
          tag_waddr = hit_r ? hit_idx_r : (inv_r ? inv_idx_r : vic_idx_r);
        end
      end
      S_STRD: blk_re = 1'b1;
      S_CMPRD: begin
        blk_re = 1'b1;
        stg_re = 1'b1;
      end
      S_OVRCHK: tag_we = match;
      S_CPRD: stg_re = 1'b1;
      S_CPWR: blk_we = 1'b1;
      default: ;
    endcase
  end

  bcm_ram #(.W(TW), .D(ENTRIES)) u_tag (
    .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
    .re(tag_re), .raddr(scan_i_r), .rdata(tag_rdata)
  );

  bcm_ram #(.W(WORD_W), .D(BD)) u_blk (
    .clk(clk), .we(blk_we), .waddr(blk_waddr), .wdata(stg_word),
    .re(blk_re), .raddr(blk_raddr), .rdata(blk_rdata)
  );

  bcm_ram #(.W(WORD_W), .D(BLOCK_WORDS)) u_stg (
    .clk(clk), .we(stg_we), .waddr(stg_waddr), .wdata(in_data_word),
    .re(stg_re), .raddr(stg_raddr), .rdata(stg_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      on_r        <= 1'b0;
      use_r       <= USE_W'(RST_USE);
      queries_r   <= '0;
      hits_r      <= '0;
      ctr_r       <= '0;
      stg_cnt_r   <= '0;
      scan_i_r    <= '0;
      ev_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_CACHE_ON: on_r <= cfg_wdata[0];
          REG_IN_USE: begin
            if ((int'(cfg_wdata) >= MIN_IN_USE) && (int'(cfg_wdata) <= ENTRIES)) begin
              use_r <= cfg_wdata;
            end
          end
          default: ;
        endcase
      end

      // drop the taken beat unless a new one loads in the same cycle
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      // scan accumulation: first hit, first free slot, largest stamp
      ev_vld_r <= (state_r == S_SCAN);
      ev_i_r   <= scan_i_r;
      if (ev_vld_r) begin
        if (match && !hit_r) begin
          hit_r     <= 1'b1;
          hit_idx_r <= ev_i_r;
        end
        if (!tag_rd.vld && !inv_r) begin
          inv_r     <= 1'b1;
          inv_idx_r <= ev_i_r;
        end
        if (tag_rd.vld && (tag_rd.stamp > best_r)) begin
          best_r    <= tag_rd.stamp;
          vic_r     <= 1'b1;
          vic_idx_r <= ev_i_r;
        end
      end

      unique case (state_r)
        S_CLR: begin
          scan_i_r <= scan_i_r + EW'(1);
          if (scan_i_r == EW'(ENTRIES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_r     <= in_opcode;
            disk_r   <= in_disk_id;
            blk_r    <= in_block_id;
            scan_i_r <= '0;
            hit_r    <= 1'b0;
            inv_r    <= 1'b0;
            vic_r    <= 1'b0;
            best_r   <= '0;
            if (in_opcode == OP_LOOKUP) begin
              if (!on_r) begin
                res_st_r <= ST_OFF;
                state_r  <= S_EMIT;
              end else begin
                queries_r <= queries_r + CNT_W'(1);
                state_r   <= S_SCAN;
              end
            end else if (in_word_last) begin
              pcnt_r    <= stg_cnt_nxt;
              stg_cnt_r <= '0;
              if (!on_r || tag_bad) begin
                res_st_r <= ST_OFF;
                state_r  <= S_EMIT;
              end else begin
                queries_r <= queries_r + CNT_W'(1);
                state_r   <= S_SCAN;
              end
            end else begin
              stg_cnt_r <= stg_cnt_nxt;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state_r <= S_SDRAIN;
          end else begin
            scan_i_r <= scan_i_r + EW'(1);
          end
        end
        S_SDRAIN: state_r <= S_DECIDE;
        S_DECIDE: begin
          w_r      <= '0;
          ovr_r    <= 1'b0;
          res_st_r <= ST_OK;
          if (op_r == OP_LOOKUP) begin
            if (hit_r) begin
              hits_r  <= hits_r + CNT_W'(1);
              ctr_r   <= ctr_r + CNT_W'(1);
              state_r <= S_STRD;
            end else begin
              res_st_r <= ST_MISS;
              state_r  <= S_EMIT;
            end
          end else if (hit_r) begin
            hits_r  <= hits_r + CNT_W'(1);
            ctr_r   <= ctr_r + CNT_W'(1);
            state_r <= S_CMPRD;
          end else if (inv_r || vic_r) begin
            dst_r   <= inv_r ? inv_idx_r : vic_idx_r;
            ctr_r   <= ctr_r + CNT_W'(1);
            state_r <= S_CPRD;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_STRD: state_r <= S_STOUT;
        S_STOUT: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            out_word_r   <= blk_rdata;
            out_last_r   <= w_end;
            out_q_r      <= queries_r;
            out_h_r      <= hits_r;
            w_r          <= w_r + WW'(1);
            state_r      <= w_end ? S_IDLE : S_STRD;
          end
        end
        S_CMPRD: state_r <= S_CMPCHK;
        S_CMPCHK: begin
          if (blk_rdata != stg_word) begin
            scan_i_r <= '0;
            state_r  <= S_OVRRD;
          end else if (w_end) begin
            res_st_r <= ST_DUP;
            state_r  <= S_EMIT;
          end else begin
            w_r     <= w_r + WW'(1);
            state_r <= S_CMPRD;
          end
        end
        S_OVRRD: state_r <= S_OVRCHK;
        S_OVRCHK: begin
          if (match) begin
            ctr_r   <= ctr_r + CNT_W'(1);
            dst_r   <= scan_i_r;
            w_r     <= '0;
            ovr_r   <= 1'b1;
            state_r <= S_CPRD;
          end else if (scan_end) begin
            state_r <= S_EMIT;
          end else begin
            scan_i_r <= scan_i_r + EW'(1);
            state_r  <= S_OVRRD;
          end
        end
        S_CPRD: state_r <= S_CPWR;
        S_CPWR: begin
          if (!w_end) begin
            w_r     <= w_r + WW'(1);
            state_r <= S_CPRD;
          end else if (ovr_r && !scan_end) begin
            scan_i_r <= scan_i_r + EW'(1);
            state_r  <= S_OVRRD;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_st_r;
            out_word_r   <= '0;
            out_last_r   <= 1'b1;
            out_q_r      <= queries_r;
            out_h_r      <= hits_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/bcm_chk.sv =====
// Port-level checks of the MRU block cache, bound to the top level.
module bcm_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   out_status,
  input logic [bcm_pkg::WORD_W-1:0]   out_read_word,
  input logic                         out_result_last,
  input logic [bcm_pkg::CNT_W-1:0]    out_query_count,
  input logic [bcm_pkg::CNT_W-1:0]    out_hit_count
);
  import bcm_pkg::*;

  // the tag sweep keeps the input closed right after reset
  a_clr_after_rst: assert property (@(posedge clk) !rst_n |=> !in_ready && !out_valid)
    else $error("input open or result shown during tag sweep");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_hits_le_queries: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hit_count <= out_query_count)
    else $error("hit count above query count");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_result_last && (out_read_word == '0))
    else $error("non-hit result not a single zero beat");

endmodule

bind block_cache_mru_replace_core bcm_chk u_bcm_chk (.*);
